FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on i_clk and is
// switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vidfl_pkg.sv
`timescale 1ns / 1ps

package vidfl_pkg;

    // Fixed widths of the channel fields.
    localparam int HANDLE_W = 16;

    // Request codes.
    typedef enum logic {
        OP_CREATE = 1'b0,
        OP_FREE   = 1'b1
    } t_opcode;

    // One request transaction.
    typedef struct packed {
        t_opcode               opcode;
        logic [HANDLE_W-1:0]   handle_in;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic [HANDLE_W-1:0]   handle_out;
        logic                  exhausted;
    } t_rsp;

endpackage

FILE: rtl/vidfl_if.sv
`timescale 1ns / 1ps

// Request channel: valid/ready handshake carrying one request.
interface vidfl_req_if import vidfl_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// Result channel: valid/ready handshake carrying one issued handle.
interface vidfl_rsp_if import vidfl_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/vidfl_slot_ram.sv
`timescale 1ns / 1ps

// Single-port slot table with a registered read. A read and a write to the
// same address in one cycle return the old contents.
module vidfl_slot_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Read-first port: the table has no reset, entries are defined once written.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/versioned_id_free_list_allocator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Generational handle allocator with a free list threaded through a slot table.
// i_req carries a request: opcode OP_CREATE asks for a handle, OP_FREE returns
// handle_in (version in the high bits, identifier in the low ID_BITS bits).
// o_rsp carries one result per create: the recycled or fresh handle, or the
// all-ones handle with exhausted set when no identifier is left. A free
// produces no result transaction.
// A request waits in the input register; when it is processed, a create's result is
// loaded into the output register and o_rsp.valid rises. Throughput: one request per
// cycle while no create is held back. The slot table is a single-port RAM with a
// registered read; each free or issuing create does one read-modify-write on it, and
// the list head read back from the RAM is forwarded to the request right behind.
// Reset clears the list head, the free count and the fresh identifier counter;
// the slot table is not cleared and needs no clearing pass.
// When the receiver holds o_rsp.ready low, the output register keeps its
// result; a free still passes, while a create waits in the input register and
// i_req.ready drops until the output register can take the new result.
module versioned_id_free_list_allocator import vidfl_pkg::*; #(
    parameter int ID_BITS      = 10,
    parameter int VERSION_BITS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vidfl_req_if.sink     i_req,
    vidfl_rsp_if.source   o_rsp
);

    localparam int HW = ID_BITS + VERSION_BITS;
    localparam int CW = ID_BITS + 1;

    typedef logic [HW-1:0]      t_handle;
    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [CW-1:0]      t_count;

    // What the request in the read stage does to the list head.
    typedef enum logic [1:0] {
        S2_NONE,
        S2_FREE,
        S2_POP
    } t_s2_kind;

    localparam t_handle HANDLE_ONES = '1;

    // Bring a channel handle to the internal handle width.
    function automatic t_handle to_handle(logic [HANDLE_W-1:0] h);
        logic [HW+HANDLE_W-1:0] w;
        w = {{HW{1'b0}}, h};
        return w[HW-1:0];
    endfunction

    // Bring an internal handle to the channel width.
    function automatic logic [HANDLE_W-1:0] to_port(t_handle h);
        logic [HW+HANDLE_W-1:0] w;
        w = {{HANDLE_W{1'b0}}, h};
        return w[HANDLE_W-1:0];
    endfunction

    // Advance the version field, wrapping within its width.
    function automatic t_handle bump_version(t_handle h);
        logic [VERSION_BITS-1:0] ver;
        ver = h[HW-1:ID_BITS] + VERSION_BITS'(1);
        return {ver, h[ID_BITS-1:0]};
    endfunction

    // Input register.
    logic       r_s1_v;
    t_opcode    r_s1_op;
    t_handle    r_s1_handle;

    // Read stage and allocator state.
    t_s2_kind   r_s2_kind;
    t_handle    r_head;
    t_count     r_count;
    t_count     r_fresh;

    // Output register.
    logic       r_out_v;
    t_rsp       r_out_item;

    t_s2_kind   n_s2_kind;
    t_count     n_count;
    t_count     n_fresh;
    t_rsp       n_out_item;

    t_handle    head_cur;
    t_handle    rd_data;
    logic       is_create;
    logic       have_free;
    logic       out_of_ids;
    logic       s1_fire;
    logic       in_ready;
    logic       ram_we;
    t_id        ram_addr;
    t_handle    ram_wdata;
    logic       out_exh_ok;
    logic       exh_create;

    // Current list head, forwarded from the slot read of the previous request.
    always_comb begin
        unique case (r_s2_kind)
            S2_NONE: head_cur = r_head;
            S2_FREE: head_cur = bump_version(rd_data);
            S2_POP:  head_cur = rd_data;
            default: head_cur = r_head;
        endcase
    end

    // Handshake: a create needs room in the output register, a free never waits.
    assign is_create  = (r_s1_op == OP_CREATE);
    assign have_free  = (r_count != '0);
    assign out_of_ids = r_fresh[ID_BITS];
    assign s1_fire    = r_s1_v && (!is_create || !r_out_v || o_rsp.ready);
    assign in_ready   = !r_s1_v || s1_fire;

    // Slot table access and next state for the request in the input register.
    always_comb begin
        ram_we     = 1'b0;
        ram_addr   = r_s1_handle[ID_BITS-1:0];
        ram_wdata  = head_cur;
        n_s2_kind  = S2_NONE;
        n_count    = r_count;
        n_fresh    = r_fresh;
        n_out_item = r_out_item;
        if (s1_fire) begin
            priority if (!is_create) begin
                // Free: the slot links to the old head, its bumped handle heads the list.
                ram_we    = 1'b1;
                n_s2_kind = S2_FREE;
                n_count   = r_count + t_count'(1);
            end else if (have_free) begin
                // Recycle the list head; its slot holds the next link.
                ram_we                = 1'b1;
                ram_addr              = head_cur[ID_BITS-1:0];
                n_s2_kind             = S2_POP;
                n_count               = r_count - t_count'(1);
                n_out_item.handle_out = to_port(head_cur);
                n_out_item.exhausted  = 1'b0;
            end else if (!out_of_ids) begin
                // Issue a fresh identifier at version zero.
                ram_we                = 1'b1;
                ram_addr              = r_fresh[ID_BITS-1:0];
                ram_wdata             = {{VERSION_BITS{1'b0}}, r_fresh[ID_BITS-1:0]};
                n_fresh               = r_fresh + t_count'(1);
                n_out_item.handle_out = to_port(ram_wdata);
                n_out_item.exhausted  = 1'b0;
            end else begin
                // No identifier left: report it and leave the state alone.
                n_out_item.handle_out = to_port(HANDLE_ONES);
                n_out_item.exhausted  = 1'b1;
            end
        end
    end

    vidfl_slot_ram #(
        .ADDR_W (ID_BITS),
        .DATA_W (HW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rd_data)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_kind <= S2_NONE;
            r_head    <= '0;
            r_count   <= '0;
            r_fresh   <= '0;
            r_out_v   <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_v <= i_req.valid;
            end
            r_s2_kind <= n_s2_kind;
            r_head    <= head_cur;
            r_count   <= n_count;
            r_fresh   <= n_fresh;
            if (s1_fire && is_create) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_s1_op     <= i_req.payload.opcode;
            r_s1_handle <= to_handle(i_req.payload.handle_in);
        end
        r_out_item <= n_out_item;
    end

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_out_item;

    // Conditions watched by the checks below.
    assign out_exh_ok = !(r_out_v && r_out_item.exhausted)
                        || (r_out_item.handle_out == to_port(HANDLE_ONES));
    assign exh_create = s1_fire && is_create && !have_free && out_of_ids;

    // An exhausted result always carries the all-ones handle.
    `ASSERT_ALWAYS(a_exh_sentinel, out_exh_ok, "exhausted result without sentinel handle")

    // The fresh counter stops at the first identifier past the table.
    `ASSERT_ALWAYS(a_fresh_bound, !out_of_ids || (r_fresh[ID_BITS-1:0] == '0), "fresh id overrun")

    // A create that finds no identifier leaves the counters untouched.
    `ASSERT_NEXT(a_exh_no_change, exh_create, $stable({r_count, r_fresh}), "exhaustion changed state")

endmodule
